// ----- rtl/wsd_pkg.sv -----
// Shared types and constants for the WebSocket text frame deframer.
// No dependencies; imported by every module of the block.
package wsd_pkg;

   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 63;
   localparam int KEY_W    = 32;
   localparam int HDRCNT_W = 3;
   localparam int KIDX_W   = 2;

   localparam logic [BYTE_W-1:0] FIN_MASK    = 8'h80;
   localparam logic [BYTE_W-1:0] MASKED_MASK = 8'h80;
   localparam logic [BYTE_W-1:0] OPCODE_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] LEN7_MASK   = 8'h7F;
   localparam logic [BYTE_W-1:0] OPCODE_TEXT = 8'h01;
   localparam logic [BYTE_W-1:0] LEN_EXT16   = 8'd126;
   localparam logic [BYTE_W-1:0] LEN_EXT64   = 8'd127;

   localparam logic [HDRCNT_W-1:0] EXT16_COUNT = 3'd1;
   localparam logic [HDRCNT_W-1:0] EXT64_COUNT = 3'd7;
   localparam logic [HDRCNT_W-1:0] KEY_COUNT   = 3'd3;

   typedef enum logic [4:0] {
      PH_HDR0    = 5'b00001,
      PH_HDR1    = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_MASKKEY = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] payload_byte;
      logic              end_of_message;
   } result_type;

endpackage

// ----- rtl/wsd_in_reg.sv -----
// Input register of the deframer: holds one received byte until the parser takes it.
// Depends on wsd_pkg for the byte width.
module wsd_in_reg (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [wsd_pkg::BYTE_W-1:0] req_stream_byte,
   input  logic                       take,
   output logic                       held_valid,
   output logic [wsd_pkg::BYTE_W-1:0] held_byte
);
   import wsd_pkg::*;

   logic              valid_ff;
   logic              valid_in;
   logic [BYTE_W-1:0] byte_ff;
   logic              load;

   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;
   assign valid_in  = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= req_stream_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

// ----- rtl/wsd_parser.sv -----
// Frame header parser and payload unmasker; updates the frame state once per item.
// Depends on wsd_pkg for the phase codes, constants and result struct.
module wsd_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [wsd_pkg::BYTE_W-1:0] stream_byte,
   output wsd_pkg::result_type        result
);
   import wsd_pkg::*;

   phase_type           phase_ff, phase_in;
   logic [HDRCNT_W-1:0] count_ff, count_in;
   logic [LEN_W-1:0]    remaining_ff, remaining_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [KIDX_W-1:0]   kidx_ff, kidx_in;
   logic                masked_ff, masked_in;
   logic                kept_ff, kept_in;

   logic [BYTE_W-1:0]   len7;
   logic [BYTE_W-1:0]   key_byte;
   logic [LEN_W-1:0]    rem_dec;

   assign len7     = stream_byte & LEN7_MASK;
   assign key_byte = masked_ff ? key_ff[{~kidx_ff, 3'b000} +: BYTE_W] : '0;
   assign rem_dec  = remaining_ff - LEN_W'(1);

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      key_in       = key_ff;
      kidx_in      = kidx_ff;
      masked_in    = masked_ff;
      kept_in      = kept_ff;
      result       = '0;
      unique case (phase_ff)
         PH_HDR1: begin
            masked_in    = (stream_byte & MASKED_MASK) != '0;
            remaining_in = '0;
            if (len7 == LEN_EXT16) begin
               count_in = EXT16_COUNT;
               phase_in = PH_EXTLEN;
            end else if (len7 == LEN_EXT64) begin
               count_in = EXT64_COUNT;
               phase_in = PH_EXTLEN;
            end else begin
               remaining_in = LEN_W'(len7);
               if (masked_in) begin
                  key_in   = '0;
                  count_in = KEY_COUNT;
                  phase_in = PH_MASKKEY;
               end else begin
                  kidx_in  = '0;
                  phase_in = (remaining_in == '0) ? PH_HDR0 : PH_PAYLOAD;
               end
            end
         end
         PH_EXTLEN: begin
            remaining_in = {remaining_ff[LEN_W-BYTE_W-1:0], stream_byte};
            if (count_ff == '0) begin
               if (masked_ff) begin
                  key_in   = '0;
                  count_in = KEY_COUNT;
                  phase_in = PH_MASKKEY;
               end else begin
                  kidx_in  = '0;
                  phase_in = (remaining_in == '0) ? PH_HDR0 : PH_PAYLOAD;
               end
            end else begin
               count_in = count_ff - HDRCNT_W'(1);
            end
         end
         PH_MASKKEY: begin
            key_in = {key_ff[KEY_W-BYTE_W-1:0], stream_byte};
            if (count_ff == '0) begin
               kidx_in  = '0;
               phase_in = (remaining_ff == '0) ? PH_HDR0 : PH_PAYLOAD;
            end else begin
               count_in = count_ff - HDRCNT_W'(1);
            end
         end
         PH_PAYLOAD: begin
            kidx_in      = kidx_ff + KIDX_W'(1);
            remaining_in = rem_dec;
            if (rem_dec == '0) begin
               phase_in = PH_HDR0;
            end
            result.valid          = kept_ff;
            result.payload_byte   = stream_byte ^ key_byte;
            result.end_of_message = (rem_dec == '0);
         end
         default: begin
            kept_in  = ((stream_byte & FIN_MASK) != '0)
                       && ((stream_byte & OPCODE_MASK) == OPCODE_TEXT);
            count_in = '0;
            phase_in = PH_HDR1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HDR0;
         count_ff     <= '0;
         remaining_ff <= '0;
         key_ff       <= '0;
         kidx_ff      <= '0;
         masked_ff    <= 1'b0;
         kept_ff      <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
         key_ff       <= key_in;
         kidx_ff      <= kidx_in;
         masked_ff    <= masked_in;
         kept_ff      <= kept_in;
      end
   end

endmodule

// ----- rtl/websocket_text_frame_deframer.sv -----
// Top level of the WebSocket text frame deframer: input register, parser, result register.
// Depends on wsd_pkg, wsd_in_reg and wsd_parser.
//
//   channel  direction  payload                                 handshake
//   req      in         req_stream_byte[7:0]                    req_valid / req_ready
//   rsp      out        rsp_payload_byte[7:0], rsp_end_of_message rsp_valid / rsp_ready
//
// One item a cycle unless rsp stalls; items pass from input register to result register.
// Header, length and mask key bytes give no result; payload bytes of kept frames give one.
// Synchronous reset clears the input and result valids and returns the parser to the header.
// A stalled result holds in the result register; the parser waits while it is full and held.
module websocket_text_frame_deframer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [wsd_pkg::BYTE_W-1:0] req_stream_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [wsd_pkg::BYTE_W-1:0] rsp_payload_byte,
   output logic                       rsp_end_of_message
);
   import wsd_pkg::*;

   logic              held_valid;
   logic [BYTE_W-1:0] held_byte;
   logic              out_free;
   logic              step;
   result_type        result;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] payload_ff;
   logic              eom_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step     = held_valid && out_free;

   wsd_in_reg u_in_reg (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_stream_byte (req_stream_byte),
      .take            (step),
      .held_valid      (held_valid),
      .held_byte       (held_byte)
   );

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .stream_byte (held_byte),
      .result      (result)
   );

   assign rsp_valid_in = out_free ? (step && result.valid) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && result.valid && out_free) begin
         payload_ff <= result.payload_byte;
         eom_ff     <= result.end_of_message;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_byte   = payload_ff;
   assign rsp_end_of_message = eom_ff;

endmodule
